// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the queue unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while in reset.
`define ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same check, kept live through reset.
`define ASSERT_CLK_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- rtl/fsqt_pkg.sv -----
package fsqt_pkg;

  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int TIME_BITS_DEF   = 32;

  localparam int LIMIT_W = 11;
  localparam int SVC_W   = 16;
  localparam int SOJ_W   = 32;
  localparam int OCC_W   = 11;
  localparam int CNT48_W = 48;
  localparam int SUM64_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE  = 2'd0,
    CFG_QUEUE_LIMIT   = 2'd1,
    CFG_SERVICE_TICKS = 2'd2
  } cfg_idx_t;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST   = 11'd1024;
  localparam logic [SVC_W-1:0]   SERVICE_TICKS_RST = 16'd2000;

endpackage

// ----- rtl/fsqt_ram.sv -----
module fsqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fixed_service_queue_tick_model_unit.sv -----
// Channel   | Ports                                   | Moves
// ----------+-----------------------------------------+---------------------------------
// input     | in_valid, in_stall, in_arrival_now      | one tick per transaction
// result    | out_valid, out_stall, out_* fields      | one result per tick
// config    | cfg_wr_en, cfg_index, cfg_wdata         | one register write per cycle
//
// Each tick first reads the head stamp from the stamp RAM (registered read),
// then updates queue state, writes the tail stamp and loads the result
// register. A new tick is taken while the last result waits; the
// update cycle holds until the result register is free.
// Reset (rst_n, synchronous) clears all counters and totals; the stamp RAM is
// not cleared, only stamps of occupied entries are ever used.
module fixed_service_queue_tick_model_unit
  import fsqt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input ticks
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_arrival_now,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic                  out_dropped,
  output logic                  out_departed,
  output logic [SOJ_W-1:0]      out_sojourn_ticks,
  output logic [OCC_W-1:0]      out_occupancy,
  output logic                  out_idle,
  output logic [CNT48_W-1:0]    out_accepted_total,
  output logic [SUM64_W-1:0]    out_sojourn_total,
  output logic [SUM64_W-1:0]    out_occupancy_total,
  output logic [CNT48_W-1:0]    out_idle_total
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // compare width wide enough for both the count and the limit register
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state_r;
  logic                 arrive_r;

  // configuration
  logic                 limit_en_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [SVC_W-1:0]     svc_r;

  // queue state
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SVC_W-1:0]     rem_r, rem_nxt;
  logic [TIME_BITS-1:0] tick_r;
  logic [CNT48_W-1:0]   acc_sum_r, acc_sum_nxt;
  logic [SUM64_W-1:0]   soj_sum_r, soj_sum_nxt;
  logic [SUM64_W-1:0]   occ_sum_r, occ_sum_nxt;
  logic [CNT48_W-1:0]   idle_sum_r, idle_sum_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 acc_r, acc_nxt;
  logic                 drop_r, drop_nxt;
  logic                 dep_r, dep_nxt;
  logic [SOJ_W-1:0]     soj_r, soj_nxt;
  logic                 idle_r, idle_nxt;

  logic                 in_take;
  logic                 commit;
  logic [TIME_BITS-1:0] head_stamp;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  // update cycle runs once the result register can take a new result
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // stamp RAM: head read on accept, tail written on a commit that accepts an arrival
  fsqt_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_stamps (
    .clk   (clk),
    .we    (commit && acc_nxt),
    .waddr (tail_r),
    .wdata (tick_r),
    .re    (in_take),
    .raddr (head_r),
    .rdata (head_stamp)
  );

  always_comb begin
    logic                 room;
    logic [SVC_W-1:0]     load_svc;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] diff;
    logic [CNT48_W:0]     add48;
    logic [CNT48_W:0]     addi;
    logic [SUM64_W:0]     add_soj;
    logic [SUM64_W:0]     add_occ;

    load_svc  = (svc_r == '0) ? SVC_W'(1) : svc_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    acc_nxt   = 1'b0;
    drop_nxt  = 1'b0;
    dep_nxt   = 1'b0;
    idle_nxt  = 1'b0;
    soj_nxt   = '0;
    acc_sum_nxt  = acc_sum_r;
    soj_sum_nxt  = soj_sum_r;
    idle_sum_nxt = idle_sum_r;

    // arrival
    room = (count_r < FULL_CNT) &&
           !(limit_en_r && (CMP_W'(count_r) >= CMP_W'(limit_r)));
    if (arrive_r) begin
      if (room) begin
        acc_nxt   = 1'b1;
        tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
        count_nxt = count_r + CNT_W'(1);
        if (count_r == '0) begin
          rem_nxt = load_svc;
        end
      end else begin
        drop_nxt = 1'b1;
      end
    end
    add48 = {1'b0, acc_sum_r} + (CNT48_W+1)'(1);
    if (acc_nxt) begin
      acc_sum_nxt = add48[CNT48_W] ? '1 : add48[CNT48_W-1:0];
    end

    // service; an empty queue before this tick means the head is the new arrival
    stamp   = (count_r == '0) ? tick_r : head_stamp;
    diff    = tick_r - stamp;
    // the sum takes the full time difference; only the result field is cut to 32 bits
    add_soj = {1'b0, soj_sum_r} + (SUM64_W+1)'(diff);
    addi    = {1'b0, idle_sum_r} + (CNT48_W+1)'(1);
    if (count_nxt != '0) begin
      if (rem_nxt <= SVC_W'(1)) begin
        dep_nxt     = 1'b1;
        soj_nxt     = SOJ_W'(diff);
        head_nxt    = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
        soj_sum_nxt = add_soj[SUM64_W] ? '1 : add_soj[SUM64_W-1:0];
        rem_nxt     = (count_nxt != CNT_W'(1)) ? load_svc : '0;
        count_nxt   = count_nxt - CNT_W'(1);
      end else begin
        rem_nxt = rem_nxt - SVC_W'(1);
      end
    end else begin
      idle_nxt     = 1'b1;
      idle_sum_nxt = addi[CNT48_W] ? '1 : addi[CNT48_W-1:0];
    end

    add_occ     = {1'b0, occ_sum_r} + (SUM64_W+1)'(count_nxt);
    occ_sum_nxt = add_occ[SUM64_W] ? '1 : add_occ[SUM64_W-1:0];

    out_valid_nxt = commit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_en_r  <= 1'b0;
      limit_r     <= QUEUE_LIMIT_RST;
      svc_r       <= SERVICE_TICKS_RST;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      tick_r      <= '0;
      acc_sum_r   <= '0;
      soj_sum_r   <= '0;
      occ_sum_r   <= '0;
      idle_sum_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_LIMIT_ENABLE:  limit_en_r <= cfg_wdata[0];
          CFG_QUEUE_LIMIT:   limit_r    <= cfg_wdata[LIMIT_W-1:0];
          CFG_SERVICE_TICKS: svc_r      <= cfg_wdata[SVC_W-1:0];
          default: ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_r    <= S_IDLE;
            head_r     <= head_nxt;
            tail_r     <= tail_nxt;
            count_r    <= count_nxt;
            rem_r      <= rem_nxt;
            tick_r     <= tick_r + TIME_BITS'(1);
            acc_sum_r  <= acc_sum_nxt;
            soj_sum_r  <= soj_sum_nxt;
            occ_sum_r  <= occ_sum_nxt;
            idle_sum_r <= idle_sum_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      arrive_r <= in_arrival_now;
    end
    if (commit) begin
      acc_r  <= acc_nxt;
      drop_r <= drop_nxt;
      dep_r  <= dep_nxt;
      soj_r  <= soj_nxt;
      idle_r <= idle_nxt;
    end
  end

  // totals and occupancy only change on commit, together with the result
  assign out_valid           = out_valid_r;
  assign out_accepted        = acc_r;
  assign out_dropped         = drop_r;
  assign out_departed        = dep_r;
  assign out_sojourn_ticks   = soj_r;
  assign out_idle            = idle_r;
  assign out_occupancy       = OCC_W'(count_r);
  assign out_accepted_total  = acc_sum_r;
  assign out_sojourn_total   = soj_sum_r;
  assign out_occupancy_total = occ_sum_r;
  assign out_idle_total      = idle_sum_r;

  `ASSERT_CLK(a_take_exec, clk, rst_n,
              in_take |=> (state_r == S_EXEC), "tick not started")
  `ASSERT_CLK(a_empty_ptrs, clk, rst_n,
              (count_r == '0) |-> (head_r == tail_r), "empty ptr skew")
  `ASSERT_CLK(a_count_hold, clk, rst_n,
              (commit && !acc_nxt && !dep_nxt) |=> (count_r == $past(count_r)),
              "count moved")
  `ASSERT_CLK(a_tail_move, clk, rst_n,
              (commit && acc_nxt) |=> (tail_r != $past(tail_r)), "tail stuck")

endmodule

// ----- verif/fixed_service_queue_tick_model_unit_tb.sv -----
module fixed_service_queue_tick_model_unit_tb;
  import fsqt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transaction on either channel before the run is called hung.
  // The slowest correct stretch is a stall run at 53 percent; the limit is far beyond it.
  localparam int QUIET_LIMIT = 2000;
  localparam int STAMP_AW    = $clog2(QUEUE_DEPTH_DEF);

  // One result transaction, fields at the port widths.
  typedef struct {
    logic               accepted;
    logic               dropped;
    logic               departed;
    logic [SOJ_W-1:0]   sojourn_ticks;
    logic [OCC_W-1:0]   occupancy;
    logic               idle;
    logic [CNT48_W-1:0] accepted_total;
    logic [SUM64_W-1:0] sojourn_total;
    logic [SUM64_W-1:0] occupancy_total;
    logic [CNT48_W-1:0] idle_total;
  } tick_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT-facing signals. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_arrival_now = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic               out_dropped;
  logic               out_departed;
  logic [SOJ_W-1:0]   out_sojourn_ticks;
  logic [OCC_W-1:0]   out_occupancy;
  logic               out_idle;
  logic [CNT48_W-1:0] out_accepted_total;
  logic [SUM64_W-1:0] out_sojourn_total;
  logic [SUM64_W-1:0] out_occupancy_total;
  logic [CNT48_W-1:0] out_idle_total;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fixed_service_queue_tick_model_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_now      (in_arrival_now),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_dropped         (out_dropped),
    .out_departed        (out_departed),
    .out_sojourn_ticks   (out_sojourn_ticks),
    .out_occupancy       (out_occupancy),
    .out_idle            (out_idle),
    .out_accepted_total  (out_accepted_total),
    .out_sojourn_total   (out_sojourn_total),
    .out_occupancy_total (out_occupancy_total),
    .out_idle_total      (out_idle_total)
  );

  // ---------------------------------------------------------------------------
  // Queue predictor. Mirrors the register file and the queue state; one call
  // per accepted input transaction advances simulated time by one tick.
  // ---------------------------------------------------------------------------
  logic                 cfg_limit_on  = 1'b0;
  logic [LIMIT_W-1:0]   cfg_max_queue = QUEUE_LIMIT_RST;
  logic [SVC_W-1:0]     cfg_service   = SERVICE_TICKS_RST;

  logic [SOJ_W-1:0]     stamp_mem [QUEUE_DEPTH_DEF];
  logic [STAMP_AW-1:0]  q_head      = '0;
  logic [STAMP_AW-1:0]  q_tail      = '0;
  logic [OCC_W-1:0]     q_count     = '0;
  logic [SVC_W-1:0]     q_remaining = '0;
  logic [SOJ_W-1:0]     q_tick      = '0;
  logic [CNT48_W-1:0]   accepted_sum  = '0;
  logic [SUM64_W-1:0]   sojourn_sum   = '0;
  logic [SUM64_W-1:0]   occupancy_sum = '0;
  logic [CNT48_W-1:0]   idle_sum      = '0;

  function automatic logic [SUM64_W-1:0] sat_add64(input logic [SUM64_W-1:0] a,
                                                   input logic [SUM64_W-1:0] b);
    logic [SUM64_W:0] s;
    s = a + b;
    return s[SUM64_W] ? '1 : s[SUM64_W-1:0];
  endfunction

  function automatic logic [CNT48_W-1:0] sat_inc48(input logic [CNT48_W-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // A zero service setting still holds the packet for one tick.
  function automatic logic [SVC_W-1:0] service_load();
    return (cfg_service == '0) ? SVC_W'(1) : cfg_service;
  endfunction

  function automatic tick_result_t serve_tick(input logic arrive);
    tick_result_t r;
    logic [SOJ_W-1:0] now;
    logic room;
    now = q_tick;
    r = '{default: '0};

    // Arrival first: stored only if both the hardware depth and the limit allow.
    if (arrive) begin
      room = (q_count < QUEUE_DEPTH_DEF);
      if (cfg_limit_on && (q_count >= cfg_max_queue)) room = 1'b0;
      if (room) begin
        stamp_mem[q_tail] = now;
        q_tail = q_tail + 1'b1;
        if (q_count == '0) q_remaining = service_load();
        q_count = q_count + 1'b1;
        r.accepted = 1'b1;
        accepted_sum = sat_inc48(accepted_sum);
      end else begin
        r.dropped = 1'b1;
      end
    end

    // Then the server looks at the front, which may be the packet just stored.
    if (q_count != '0) begin
      if (q_remaining <= 1) begin
        r.sojourn_ticks = now - stamp_mem[q_head];
        q_head = q_head + 1'b1;
        q_count = q_count - 1'b1;
        r.departed = 1'b1;
        sojourn_sum = sat_add64(sojourn_sum, SUM64_W'(r.sojourn_ticks));
        q_remaining = (q_count != '0) ? service_load() : '0;
      end else begin
        q_remaining = q_remaining - 1'b1;
      end
    end else begin
      r.idle = 1'b1;
      idle_sum = sat_inc48(idle_sum);
    end

    occupancy_sum = sat_add64(occupancy_sum, SUM64_W'(q_count));
    q_tick = q_tick + 1'b1;

    r.occupancy       = q_count;
    r.accepted_total  = accepted_sum;
    r.sojourn_total   = sojourn_sum;
    r.occupancy_total = occupancy_sum;
    r.idle_total      = idle_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard and error reporting.
  // ---------------------------------------------------------------------------
  tick_result_t predicted_ticks[$];
  int error_count  = 0;
  int result_count = 0;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             result_count, name, got, want));
  endtask

  // One process watches all three ports at each edge, in a fixed order:
  // register writes, then the result channel, then the input channel.
  // Values read here are the ones the DUT saw at this same edge.
  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LIMIT_ENABLE:  cfg_limit_on  = cfg_wdata[0];
          CFG_QUEUE_LIMIT:   cfg_max_queue = cfg_wdata[LIMIT_W-1:0];
          CFG_SERVICE_TICKS: cfg_service   = cfg_wdata[SVC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        result_count++;
        if (predicted_ticks.size() == 0) begin
          report_error($sformatf("result %0d arrived with no tick outstanding",
                                 result_count));
        end else begin
          want = predicted_ticks.pop_front();
          check_field("accepted",        out_accepted,        want.accepted);
          check_field("dropped",         out_dropped,         want.dropped);
          check_field("departed",        out_departed,        want.departed);
          check_field("sojourn_ticks",   out_sojourn_ticks,   want.sojourn_ticks);
          check_field("occupancy",       out_occupancy,       want.occupancy);
          check_field("idle",            out_idle,            want.idle);
          check_field("accepted_total",  out_accepted_total,  want.accepted_total);
          check_field("sojourn_total",   out_sojourn_total,   want.sojourn_total);
          check_field("occupancy_total", out_occupancy_total, want.occupancy_total);
          check_field("idle_total",      out_idle_total,      want.idle_total);
        end
      end

      if (in_valid && !in_stall)
        predicted_ticks.push_back(serve_tick(in_arrival_now));
    end

    // Receiver back-pressure for the next cycle.
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Hang detection: counts edges with no transaction on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("fixed_service_queue_tick_model_unit_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered right after a rising edge and drive with
  // nonblocking assignments, so the DUT picks the values up on the next edge.
  // ---------------------------------------------------------------------------

  // Offer one tick; valid stays high afterwards unless the next call idles.
  task automatic send_tick(input logic arrive);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_arrival_now <= arrive;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_traffic(input int count, input int arrival_pct);
    repeat (count) send_tick($urandom_range(0, 99) < arrival_pct);
  endtask

  // Drop valid, let every outstanding tick come back, then a short pause so
  // the tick pipeline is certainly empty before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short directed walk over the corners of the queue rules.
  task automatic test_directed_corners();
    set_idling(0, 0);
    send_tick(1'b0);                          // reset settings, empty queue: idle tick
    settle();

    program_reg(CFG_SERVICE_TICKS, 16'd0);    // zero service behaves as one tick
    send_tick(1'b1);                          // stored and departs in the same tick
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    program_reg(CFG_SERVICE_TICKS, 16'd3);    // build a small backlog
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // Packet already in service keeps its count of 3; followers load 6.
    program_reg(CFG_SERVICE_TICKS, 16'd6);
    repeat (5) send_tick(1'b0);
    settle();

    // Only bit 0 / the low 11 bits count: this is limit on with a zero limit.
    program_reg(CFG_LIMIT_ENABLE, 16'hFFFF);
    program_reg(CFG_QUEUE_LIMIT, 16'hF800);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    program_reg(CFG_QUEUE_LIMIT, 16'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    program_reg(CFG_QUEUE_LIMIT, 16'd2047);   // limit above the hardware depth
    send_tick(1'b1);
    settle();
  endtask

  // Unlimited queue, short service, sparse arrivals, no idling on either side.
  task automatic test_light_load();
    set_idling(0, 0);
    program_reg(CFG_LIMIT_ENABLE, 16'h0000);
    program_reg(CFG_SERVICE_TICKS, 16'($urandom_range(1, 3)));
    run_traffic(200, 30);
    settle();
  endtask

  // Small limits under heavy arrivals: many drops. Sender idles.
  task automatic test_limited_queue();
    set_idling(53, 0);
    program_reg(CFG_LIMIT_ENABLE, 16'h0001);
    repeat (4) begin
      program_reg(CFG_QUEUE_LIMIT, 16'($urandom_range(1, 6)));
      program_reg(CFG_SERVICE_TICKS, 16'($urandom_range(2, 8)));
      run_traffic(50, 70);
      settle();
    end
  endtask

  // Service retuned between bursts while packets sit in the queue. Receiver stalls.
  task automatic test_service_retune();
    set_idling(0, 53);
    program_reg(CFG_LIMIT_ENABLE, 16'h0000);
    repeat (6) begin
      program_reg(CFG_SERVICE_TICKS, 16'($urandom_range(1, 6)));
      run_traffic(40, 50);
      settle();
    end
  endtask

  // Random settings per chunk, junk in the unused data bits, both sides idling.
  task automatic test_mixed_settings();
    set_idling(30, 30);
    repeat (5) begin
      program_reg(CFG_LIMIT_ENABLE, 16'($urandom));
      if ($urandom_range(0, 1))
        program_reg(CFG_QUEUE_LIMIT, 16'($urandom_range(0, 8)));
      else
        program_reg(CFG_QUEUE_LIMIT, 16'($urandom));
      program_reg(CFG_SERVICE_TICKS, 16'($urandom_range(0, 4)));
      run_traffic(50, $urandom_range(10, 90));
      settle();
    end
  endtask

  // Fill all 1024 stamp entries: service outlasts the fill, so the hardware depth
  // decides the drops while the enabled limit sits above it. The tail pointer
  // wraps here. The largest service setting is written last; it only affects
  // packets that have not reached the front.
  task automatic test_full_depth();
    set_idling(0, 0);
    program_reg(CFG_LIMIT_ENABLE, 16'h0001);
    program_reg(CFG_QUEUE_LIMIT, 16'hFFFF);
    program_reg(CFG_SERVICE_TICKS, 16'd1200);
    run_traffic(1100, 97);
    settle();
    program_reg(CFG_SERVICE_TICKS, 16'hFFFF);
    set_idling(30, 30);
    run_traffic(30, 50);
    settle();
  endtask

  initial begin : run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_light_load();
    test_limited_queue();
    test_service_retune();
    test_mixed_settings();
    test_full_depth();

    // Give any stray result time to show, then flag ticks that never produced a result.
    repeat (8) @(posedge clk);
    if (predicted_ticks.size() != 0)
      report_error($sformatf("%0d ticks never produced a result", predicted_ticks.size()));

    if (error_count == 0) begin
      $display("fixed_service_queue_tick_model_unit_tb: done, clean");
    end else begin
      $display("fixed_service_queue_tick_model_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
